/* rtl/core/cti_pkg.sv */
package cti_pkg;

  localparam int ACC_W          = 256;
  localparam int CHUNK_W        = 32;
  localparam int THR_W          = 41;
  localparam int DECAY_W        = 64;
  localparam int REQ_W          = 41;
  localparam int DELAY_W        = 48;
  localparam int NUM_W          = 43;
  localparam int SEQ_W          = 44;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;
  localparam int MAX_CHUNKS_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_CHUNK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 2'd2;

  localparam logic [CHUNK_W-1:0] CHUNK_RST  = 32'd2097152;
  localparam logic [THR_W-1:0]   THRESH_RST = 41'd1073741824;
  localparam logic [DECAY_W-1:0] DECAY_RST  = 64'd281474976710656;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_QUOT, S_PLAN, S_NEXT, S_LOAD, S_MUL, S_FIX,
    S_ACC, S_STORE, S_DIFF, S_CHUNK, S_FINAL, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_QU, PH_QL, PH_FIRST, PH_CUBE, PH_CHUNK, PH_LAST, PH_END
  } phase_t;

  typedef enum logic {ALU_ADD, ALU_SUB} alu_op_t;

endpackage

/* rtl/core/cti_alu.sv */
module cti_alu (
  input  logic [cti_pkg::ACC_W-1:0] a,
  input  logic [cti_pkg::ACC_W-1:0] b,
  input  cti_pkg::alu_op_t          op,
  output logic [cti_pkg::ACC_W-1:0] y
);

  // Wide adder shared by multiply, rounding, accumulation and differencing.
  always_comb begin
    unique case (op)
      cti_pkg::ALU_ADD: y = a + b;
      cti_pkg::ALU_SUB: y = a - b;
    endcase
  end

endmodule

/* rtl/core/cubic_throttle_interval_core.sv */
// Only one request is worked on at a time: s_tready is high only in the idle state.
// The shared 256-bit adder and the bit-serial multiply/divide sequencer compute two
// quotients, up to two partial chunk terms and N whole chunks (N <= MAX_CHUNKS).
// Invalid arguments go straight to the result; chunk overflow stops after the quotients.
// A result waits in the output register.
// Reset: synchronous; configuration returns to its defaults, no clearing pass.
module cubic_throttle_interval_core #(
  parameter int MAX_CHUNKS = cti_pkg::MAX_CHUNKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [87:0]                    s_tdata,   // req_bytes[40:0], held_bytes[81:41]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [47:0]                    m_tdata,   // delay_us[47:0]
  output logic [1:0]                     m_tuser,   // bad_argument[0], saturated[1]
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cti_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_CHUNKS + 1);
  localparam int AW = cti_pkg::ACC_W;
  localparam int SW = cti_pkg::SEQ_W;
  localparam int NW = cti_pkg::NUM_W;

  cti_pkg::state_t  state, state_next;
  cti_pkg::phase_t  phase;
  cti_pkg::alu_op_t alu_op;

  logic [cti_pkg::CHUNK_W-1:0] chunk;
  logic [cti_pkg::THR_W-1:0]   thresh;
  logic [cti_pkg::DECAY_W-1:0] decay;

  logic [AW-1:0] acc, w, p, d0, d1, d2, d3;
  logic [AW-1:0] alu_a, alu_b, alu_y;
  logic [31:0]   rem;
  logic [7:0]    iter;
  logic [1:0]    mpass, eidx, csub;
  logic [2:0]    dstep;
  logic [SW-1:0] mreg;
  logic [SW-1:0] q_u, q_l;
  logic [32:0]   r_u, r_l;
  logic [CW-1:0] cnt_v, chunks_left;
  logic [40:0]   req, part_first;
  logic [31:0]   part_last;
  logic          first_ok, last_ok;
  logic [NW-1:0] nl_mag;
  logic          nu_neg, nl_neg;
  logic [47:0]   res_delay;
  logic          res_bad, res_sat;

  // input side
  logic [40:0]   in_req, in_held;
  logic [41:0]   ov;
  logic [NW-1:0] nu, nl, nu_mag, nl_mag_in;
  logic          bad_in, accept;

  assign in_req    = s_tdata[40:0];
  assign in_held   = s_tdata[81:41];
  assign ov        = {1'b0, in_held} - {1'b0, thresh};
  assign nu        = {ov[41], ov} + {2'b0, in_req};
  assign nl        = {ov[41], ov} + {11'b0, chunk} - 43'd1;
  assign nu_mag    = nu[NW-1] ? -nu : nu;
  assign nl_mag_in = nl[NW-1] ? -nl : nl;
  assign bad_in    = (in_req == '0) || (in_held == '0) || (chunk == '0) ||
                     (thresh == '0) || (decay == '0);
  assign s_tready  = (state == cti_pkg::S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // divide step: one quotient bit per cycle against chunk
  logic [32:0] rem_sh, rem_sub;
  logic        fits;
  logic [31:0] rem_new;
  assign rem_sh  = {rem, w[AW-1]};
  assign rem_sub = rem_sh - {1'b0, chunk};
  assign fits    = rem_sh >= {1'b0, chunk};
  assign rem_new = fits ? rem_sub[31:0] : rem_sh[31:0];

  // quotient sign fix-up
  logic          quot_neg;
  logic [SW-1:0] qv, q_signed;
  logic [32:0]   r_signed;
  assign quot_neg = (phase == cti_pkg::PH_QU) ? nu_neg : nl_neg;
  assign qv       = {1'b0, w[NW-1:0]};
  assign q_signed = quot_neg ? -qv : qv;
  assign r_signed = quot_neg ? -{1'b0, rem} : {1'b0, rem};

  // plan values
  logic [44:0] cnt_s;
  logic        over;
  logic [34:0] cm;
  logic [40:0] cm41;
  assign cnt_s = {q_u[SW-1], q_u} - {q_l[SW-1], q_l};
  assign over  = !cnt_s[44] && (cnt_s[43:0] > 44'(MAX_CHUNKS));
  assign cm    = {3'b0, chunk} - 35'd1 - {{2{r_l[32]}}, r_l};
  assign cm41  = {6'b0, cm};

  // term operands
  logic [SW-1:0] seq_sel, seq_mag, term_part;
  logic          seq_neg;
  always_comb begin
    unique case (phase)
      cti_pkg::PH_FIRST: seq_sel = q_l + 44'd1;
      cti_pkg::PH_CUBE:  seq_sel = q_u + 44'd1 + 44'(eidx);
      cti_pkg::PH_LAST:  seq_sel = q_u + 44'd1 + 44'(cnt_v);
      default:           seq_sel = q_u;
    endcase
  end
  assign seq_neg   = seq_sel[SW-1];
  assign seq_mag   = seq_neg ? -seq_sel : seq_sel;
  assign term_part = (phase == cti_pkg::PH_LAST) ? {12'b0, part_last} : {3'b0, part_first};

  logic [AW-1:0] d_hi, d_lo;
  always_comb begin
    unique case (dstep)
      3'd1, 3'd4: begin d_hi = d2; d_lo = d1; end
      3'd2:       begin d_hi = d1; d_lo = d0; end
      default:    begin d_hi = d3; d_lo = d2; end
    endcase
  end

  cti_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .op (alu_op),
    .y  (alu_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cti_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_a      = '0;
    alu_b      = '0;
    alu_op     = cti_pkg::ALU_ADD;
    unique case (state)
      cti_pkg::S_IDLE: begin
        if (accept) state_next = bad_in ? cti_pkg::S_DONE : cti_pkg::S_DIV;
      end
      cti_pkg::S_DIV: begin
        if (iter == '0) begin
          state_next = (phase == cti_pkg::PH_QU || phase == cti_pkg::PH_QL) ?
                       cti_pkg::S_QUOT : cti_pkg::S_FIX;
        end
      end
      cti_pkg::S_QUOT: begin
        state_next = (phase == cti_pkg::PH_QU) ? cti_pkg::S_DIV : cti_pkg::S_PLAN;
      end
      cti_pkg::S_PLAN: state_next = over ? cti_pkg::S_DONE : cti_pkg::S_NEXT;
      cti_pkg::S_NEXT: begin
        unique case (phase)
          cti_pkg::PH_FIRST: if (first_ok) state_next = cti_pkg::S_LOAD;
          cti_pkg::PH_CUBE:  if (cnt_v != '0) state_next = cti_pkg::S_LOAD;
          cti_pkg::PH_LAST:  if (last_ok) state_next = cti_pkg::S_LOAD;
          default:           state_next = cti_pkg::S_FINAL;
        endcase
      end
      cti_pkg::S_LOAD: state_next = cti_pkg::S_MUL;
      cti_pkg::S_MUL: begin
        alu_a = {p[AW-2:0], 1'b0};
        alu_b = mreg[SW-1] ? w : '0;
        if (iter == '0) begin
          if (mpass == 2'd2 && phase == cti_pkg::PH_CUBE) state_next = cti_pkg::S_STORE;
          else if (mpass == 2'd3) state_next = cti_pkg::S_DIV;
        end
      end
      cti_pkg::S_FIX: begin
        // floor for a negative term rounds the magnitude up
        alu_a      = w;
        alu_b      = {{(AW-1){1'b0}}, seq_neg && (rem != '0)};
        state_next = cti_pkg::S_ACC;
      end
      cti_pkg::S_ACC: begin
        alu_a      = acc;
        alu_b      = w;
        alu_op     = seq_neg ? cti_pkg::ALU_SUB : cti_pkg::ALU_ADD;
        state_next = cti_pkg::S_NEXT;
      end
      cti_pkg::S_STORE: begin
        alu_b      = w;
        alu_op     = seq_neg ? cti_pkg::ALU_SUB : cti_pkg::ALU_ADD;
        state_next = (eidx == 2'd3) ? cti_pkg::S_DIFF : cti_pkg::S_LOAD;
      end
      cti_pkg::S_DIFF: begin
        alu_a  = d_hi;
        alu_b  = d_lo;
        alu_op = cti_pkg::ALU_SUB;
        if (dstep == 3'd5) state_next = cti_pkg::S_CHUNK;
      end
      cti_pkg::S_CHUNK: begin
        unique case (csub)
          2'd0: begin alu_a = acc; alu_b = d0; end
          2'd1: begin alu_a = d0;  alu_b = d1; end
          2'd2: begin alu_a = d1;  alu_b = d2; end
          2'd3: begin alu_a = d2;  alu_b = d3; end
        endcase
        if (csub == 2'd3 && chunks_left == CW'(1)) state_next = cti_pkg::S_NEXT;
      end
      cti_pkg::S_FINAL: state_next = cti_pkg::S_DONE;
      cti_pkg::S_DONE: if (!m_tvalid || m_tready) state_next = cti_pkg::S_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk  <= cti_pkg::CHUNK_RST;
      thresh <= cti_pkg::THRESH_RST;
      decay  <= cti_pkg::DECAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cti_pkg::REG_CHUNK:  chunk  <= cfg_data[cti_pkg::CHUNK_W-1:0];
        cti_pkg::REG_THRESH: thresh <= cfg_data[cti_pkg::THR_W-1:0];
        cti_pkg::REG_DECAY:  decay  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == cti_pkg::S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cti_pkg::S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= res_delay;
      m_tuser <= {res_sat, res_bad};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cti_pkg::PH_QU;
    end else begin
      unique case (state)
        cti_pkg::S_IDLE: begin
          if (accept) begin
            req       <= in_req;
            nu_neg    <= nu[NW-1];
            nl_neg    <= nl[NW-1];
            nl_mag    <= nl_mag_in;
            w         <= {nu_mag, {(AW-NW){1'b0}}};
            rem       <= '0;
            iter      <= 8'(NW - 1);
            phase     <= cti_pkg::PH_QU;
            res_bad   <= 1'b1;
            res_sat   <= 1'b0;
            res_delay <= '0;
          end
        end
        cti_pkg::S_DIV: begin
          rem  <= rem_new;
          w    <= {w[AW-2:0], fits};
          iter <= iter - 8'd1;
        end
        cti_pkg::S_QUOT: begin
          if (phase == cti_pkg::PH_QU) begin
            q_u   <= q_signed;
            r_u   <= r_signed;
            w     <= {nl_mag, {(AW-NW){1'b0}}};
            rem   <= '0;
            iter  <= 8'(NW - 1);
            phase <= cti_pkg::PH_QL;
          end else begin
            q_l <= q_signed;
            r_l <= r_signed;
          end
        end
        cti_pkg::S_PLAN: begin
          res_bad <= 1'b0;
          if (over) begin
            res_sat   <= 1'b1;
            res_delay <= '1;
          end else begin
            cnt_v       <= cnt_s[44] ? '0 : cnt_s[CW-1:0];
            chunks_left <= cnt_s[44] ? '0 : cnt_s[CW-1:0];
            acc         <= '0;
            part_first  <= (req < cm41) ? req : cm41;
            first_ok    <= (cm != '0);
            last_ok     <= !($signed(q_l) > $signed(q_u)) && !r_u[32] && (r_u != '0);
            part_last   <= r_u[31:0];
            phase       <= cti_pkg::PH_FIRST;
          end
        end
        cti_pkg::S_NEXT: begin
          unique case (phase)
            cti_pkg::PH_FIRST: if (!first_ok) phase <= cti_pkg::PH_CUBE;
            cti_pkg::PH_CUBE: begin
              if (cnt_v != '0) eidx <= 2'd0;
              else phase <= cti_pkg::PH_LAST;
            end
            cti_pkg::PH_LAST: if (!last_ok) phase <= cti_pkg::PH_END;
            default: ;
          endcase
        end
        cti_pkg::S_LOAD: begin
          w     <= {{(AW-cti_pkg::DECAY_W){1'b0}}, decay};
          p     <= '0;
          mpass <= 2'd0;
          mreg  <= seq_mag;
          iter  <= 8'(SW - 1);
        end
        cti_pkg::S_MUL: begin
          p    <= alu_y;
          mreg <= {mreg[SW-2:0], 1'b0};
          iter <= iter - 8'd1;
          if (iter == '0) begin
            w    <= alu_y;
            p    <= '0;
            iter <= 8'(SW - 1);
            if (mpass == 2'd3) begin
              rem  <= '0;
              iter <= 8'(AW - 1);
            end else if (!(mpass == 2'd2 && phase == cti_pkg::PH_CUBE)) begin
              mpass <= mpass + 2'd1;
              mreg  <= (mpass == 2'd2) ? term_part : seq_mag;
            end
          end
        end
        cti_pkg::S_FIX: w <= alu_y;
        cti_pkg::S_ACC: begin
          acc   <= alu_y;
          phase <= (phase == cti_pkg::PH_FIRST) ? cti_pkg::PH_CUBE : cti_pkg::PH_END;
        end
        cti_pkg::S_STORE: begin
          unique case (eidx)
            2'd0: d0 <= alu_y;
            2'd1: d1 <= alu_y;
            2'd2: d2 <= alu_y;
            2'd3: d3 <= alu_y;
          endcase
          eidx  <= eidx + 2'd1;
          dstep <= 3'd0;
        end
        cti_pkg::S_DIFF: begin
          // turn cubes at four sequences into forward differences
          unique case (dstep)
            3'd1, 3'd4: d2 <= alu_y;
            3'd2:       d1 <= alu_y;
            default:    d3 <= alu_y;
          endcase
          dstep <= dstep + 3'd1;
          if (dstep == 3'd5) begin
            phase <= cti_pkg::PH_CHUNK;
            csub  <= 2'd0;
          end
        end
        cti_pkg::S_CHUNK: begin
          unique case (csub)
            2'd0: acc <= alu_y;
            2'd1: d0  <= alu_y;
            2'd2: d1  <= alu_y;
            2'd3: d2  <= alu_y;
          endcase
          csub <= csub + 2'd1;
          if (csub == 2'd3) begin
            chunks_left <= chunks_left - CW'(1);
            if (chunks_left == CW'(1)) phase <= cti_pkg::PH_LAST;
          end
        end
        cti_pkg::S_FINAL: begin
          if (acc[AW-1]) begin
            res_delay <= '0;
          end else if (acc[AW-1:96] != '0) begin
            res_delay <= '1;
            res_sat   <= 1'b1;
          end else begin
            res_delay <= acc[95:48];
          end
        end
        cti_pkg::S_DONE: ;
      endcase
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
    else $error("bad argument result carries a delay");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (m_tdata == '1))
    else $error("saturated result not at maximum");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == cti_pkg::S_DIV) |-> (rem < chunk))
    else $error("divider remainder out of range");

  a_chunk_left: assert property (@(posedge clk) disable iff (rst)
    (state == cti_pkg::S_CHUNK) |-> (chunks_left != '0))
    else $error("chunk walk past its count");

endmodule

/* tb/cubic_throttle_interval_core_test.sv */
`timescale 1ns / 1ps

typedef struct packed {
  logic [cti_pkg::DELAY_W-1:0] delay_us;
  logic                        bad_argument;
  logic                        saturated;
} throttle_result_t;

class throttle_scoreboard;
  logic [cti_pkg::CHUNK_W-1:0] chunk_bytes;
  logic [cti_pkg::THR_W-1:0]   trigger_threshold;
  logic [cti_pkg::DECAY_W-1:0] decay_q48;
  int                          max_chunks;
  throttle_result_t            pending_delays[$];
  int                          errors;
  int                          checked;
  int                          saturated_seen;
  int                          bad_seen;

  function new(int max_c);
    max_chunks        = max_c;
    chunk_bytes       = cti_pkg::CHUNK_RST;
    trigger_threshold = cti_pkg::THRESH_RST;
    decay_q48         = cti_pkg::DECAY_RST;
    errors            = 0;
    checked           = 0;
    saturated_seen    = 0;
    bad_seen          = 0;
  endfunction

  function void write_reg(logic [cti_pkg::CFG_IDX_W-1:0] idx,
                          logic [cti_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      cti_pkg::REG_CHUNK:  chunk_bytes = value[cti_pkg::CHUNK_W-1:0];
      cti_pkg::REG_THRESH: trigger_threshold = value[cti_pkg::THR_W-1:0];
      cti_pkg::REG_DECAY:  decay_q48 = value;
      default: ;
    endcase
  endfunction

  // acc += floor(decay * seq^3 * part / chunk), wrapping at 256 bits
  function logic [cti_pkg::ACC_W-1:0] add_cubic_term(logic [cti_pkg::ACC_W-1:0] acc,
                                                     longint seq, longint part);
    logic [cti_pkg::ACC_W-1:0] prod;
    logic [cti_pkg::ACC_W-1:0] rem;
    logic [cti_pkg::ACC_W-1:0] mag;
    prod = {192'd0, decay_q48};
    mag  = {192'd0, (seq < 0) ? -seq : seq};
    prod = prod * mag;
    prod = prod * mag;
    prod = prod * mag;
    prod = prod * {192'd0, part};
    rem  = prod % {224'd0, chunk_bytes};
    prod = prod / {224'd0, chunk_bytes};
    if (seq < 0) begin
      if (rem != 0) prod = prod + 1;
      return acc - prod;
    end
    return acc + prod;
  endfunction

  function throttle_result_t predict_delay(logic [cti_pkg::REQ_W-1:0] req_b,
                                           logic [cti_pkg::REQ_W-1:0] held_b);
    throttle_result_t r;
    logic [cti_pkg::ACC_W-1:0] acc;
    longint c, ov, upper, lower, cnt, first, last, seq;
    r   = '0;
    acc = '0;
    if (req_b == 0 || held_b == 0 || chunk_bytes == 0 || trigger_threshold == 0 ||
        decay_q48 == 0) begin
      r.bad_argument = 1'b1;
      return r;
    end
    c     = longint'(chunk_bytes);
    ov    = longint'(held_b) - longint'(trigger_threshold);
    upper = (ov + longint'(req_b)) / c * c;
    lower = (ov + c - 1) / c * c;
    cnt   = (upper - lower) / c;
    if (cnt < 0) cnt = 0;
    if (cnt > max_chunks) begin
      r.delay_us  = '1;
      r.saturated = 1'b1;
      return r;
    end
    first = lower - ov;
    if (longint'(req_b) < first) first = longint'(req_b);
    if (first > 0) acc = add_cubic_term(acc, (ov + c - 1) / c + 1, first);
    seq = upper / c + 1;
    for (longint k = 0; k < cnt; k++) begin
      acc = add_cubic_term(acc, seq, c);
      seq++;
    end
    last = (lower > upper) ? 0 : (ov + longint'(req_b) - upper);
    if (last > 0) acc = add_cubic_term(acc, seq, last);
    // negative sum clamps to zero
    if (acc[cti_pkg::ACC_W-1]) return r;
    if (acc[cti_pkg::ACC_W-1:96] != 0) begin
      r.delay_us  = '1;
      r.saturated = 1'b1;
      return r;
    end
    r.delay_us = acc[95:48];
    return r;
  endfunction

  function void note_request(logic [87:0] beat);
    pending_delays.push_back(predict_delay(beat[40:0], beat[81:41]));
  endfunction

  function void check_result(logic [47:0] delay, logic [1:0] flags);
    throttle_result_t want;
    if (pending_delays.size() == 0) begin
      $error("result beat with nothing pending: delay_us %0d flags %b", delay, flags);
      errors++;
      return;
    end
    want = pending_delays.pop_front();
    checked++;
    if (want.saturated) saturated_seen++;
    if (want.bad_argument) bad_seen++;
    if (delay !== want.delay_us) begin
      $error("delay_us: expected %0d, got %0d", want.delay_us, delay);
      errors++;
    end
    if (flags[0] !== want.bad_argument) begin
      $error("bad_argument: expected %0b, got %0b", want.bad_argument, flags[0]);
      errors++;
    end
    if (flags[1] !== want.saturated) begin
      $error("saturated: expected %0b, got %0b", want.saturated, flags[1]);
      errors++;
    end
  endfunction
endclass

module cubic_throttle_interval_core_test;

  localparam logic [cti_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam longint BYTES_MAX   = 64'd1099511627776;
  localparam longint CYCLE_LIMIT = 64'd20000000;
  localparam int     HOLD_CYCLES = 8000;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [87:0]                    s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [47:0]                    m_tdata;
  logic [1:0]                     m_tuser;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [cti_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cti_pkg::CFG_DATA_W-1:0] cfg_data;

  throttle_scoreboard delay_board;
  bit                 hold_request;
  longint             cycle_count;
  int                 sent_items;

  cubic_throttle_interval_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) delay_board.note_request(s_tdata);
    if (!rst && m_tvalid && m_tready) delay_board.check_result(m_tdata, m_tuser);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(0, 3);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  function automatic longint rand64();
    return longint'({$urandom, $urandom});
  endfunction

  function automatic longint clamp_bytes(longint v, longint lo);
    if (v < lo) return lo;
    if (v > BYTES_MAX) return BYTES_MAX;
    return v;
  endfunction

  task automatic send_request(longint req_b, longint held_b);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, held_b[40:0], req_b[40:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (delay_board.pending_delays.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(logic [cti_pkg::CFG_IDX_W-1:0] idx,
                                logic [cti_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    delay_board.write_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(longint chunk, longint thresh, logic [63:0] decay);
    write_register(cti_pkg::REG_CHUNK, chunk);
    write_register(cti_pkg::REG_THRESH, thresh);
    write_register(cti_pkg::REG_DECAY, decay);
  endtask

  // mostly requests landing a few chunks around the trigger level
  task automatic send_random_request();
    longint c, thr, req_b, held_b, span;
    int mode;
    c    = longint'(delay_board.chunk_bytes);
    thr  = longint'(delay_board.trigger_threshold);
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      span   = (mode < 2) ? longint'($urandom_range(13, 1030)) : longint'($urandom_range(1, 12));
      held_b = clamp_bytes(thr + ((rand64() & 64'h7fff_ffff_ffff_ffff) % (6 * c + 1)) - 3 * c, 1);
      req_b  = clamp_bytes(((rand64() & 64'h7fff_ffff_ffff_ffff) % (span * c)) + 1, 1);
    end else if (mode < 80) begin
      held_b = clamp_bytes(thr - ((rand64() & 64'h7fff_ffff_ffff_ffff) % (20 * c + 1)), 1);
      req_b  = clamp_bytes(((rand64() & 64'h7fff_ffff_ffff_ffff) % (10 * c)) + 1, 1);
    end else if (mode < 96) begin
      held_b = clamp_bytes(rand64() & 64'h1ff_ffff_ffff, 0);
      req_b  = clamp_bytes(rand64() & 64'h1ff_ffff_ffff, 0);
    end else begin
      held_b = ($urandom_range(0, 1) != 0) ? 0 : clamp_bytes(rand64() & 64'h1ff_ffff_ffff, 1);
      req_b  = (held_b != 0) ? 0 : longint'($urandom_range(0, 1000));
    end
    send_request(req_b, held_b);
  endtask

  initial begin
    longint c;
    logic [63:0] decay;
    delay_board  = new(cti_pkg::MAX_CHUNKS_DEF);
    hold_request = 1'b0;
    cycle_count  = 0;
    sent_items   = 0;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = cti_pkg::REG_CHUNK;
    cfg_data     = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: zero arguments, negative sum, whole and partial chunks, chunk limit
    c = 2097152;
    send_request(0, 12345);
    send_request(777, 0);
    send_request(0, 0);
    send_request(BYTES_MAX, BYTES_MAX);
    send_request(1, 1);
    send_request(5 * c, 1073741824);
    send_request(3 * c + 123, 1073741824 + c / 2);
    send_request(5, 1073741824 + 10);
    send_request(4 * c, 1073741824 - 2 * c - 7);
    send_request(1024 * c, 1073741824);
    send_request(1025 * c, 1073741824);
    send_request(c - 1, 1073741824 + 1);
    drain_results();

    // upper extremes of the chunk and decay registers, threshold at BYTES_MAX
    load_settings(64'd4294967295, BYTES_MAX, 64'hffff_ffff_ffff_ffff);
    send_request(BYTES_MAX, BYTES_MAX);
    send_request(BYTES_MAX, 1);
    send_request(64'd4294967295, BYTES_MAX - 100);
    send_request(123456789, BYTES_MAX);
    drain_results();

    // delay overflow; unmapped index must leave the chunk size alone
    load_settings(1000, 1, 64'hffff_ffff_ffff_ffff);
    write_register(REG_UNMAPPED, 64'd7);
    send_request(500 * 1000, BYTES_MAX);
    send_request(1, BYTES_MAX);
    send_request(2500, 1);
    drain_results();

    // lower extremes
    load_settings(1, 1, 1);
    send_request(1, 1);
    send_request(1024, 1);
    send_request(1025, 1);
    send_request(BYTES_MAX, BYTES_MAX);
    drain_results();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: c = $urandom_range(1, 4096);
        1: c = longint'($urandom) | 1;
        2: c = $urandom_range(1, 64);
        default: c = $urandom_range(1, 1 << 22);
      endcase
      decay = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} | 64'd1
                                          : 64'd1 << $urandom_range(30, 52);
      load_settings(c, clamp_bytes(rand64() & 64'h1ff_ffff_ffff, 1), decay);
      if (phase == 2) hold_request = 1'b1;
      repeat (100) send_random_request();
      drain_results();
    end

    $display("Checked %0d results from %0d requests over nine register settings;",
             delay_board.checked, sent_items);
    $display("%0d saturated, %0d invalid arguments, one long output stall.",
             delay_board.saturated_seen, delay_board.bad_seen);
    if (delay_board.errors == 0 && delay_board.pending_delays.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
